// ===== sv/uctc_pkg.sv =====
`timescale 1ns / 1ps
// uctc_pkg: constants, types and calendar tables for the Unix time converter.
// No dependencies; used by the pipeline control and the top level.
package uctc_pkg;

  // Operation codes
  typedef enum logic {
    OP_TO_UNIX   = 1'b0,
    OP_FROM_UNIX = 1'b1
  } op_t;

  localparam int NUM_STAGES = 7;

  // Time constants
  localparam logic [31:0] EPOCH_2000 = 32'd946684800;   // 2000-01-01 00:00:00
  localparam logic [31:0] LAST_SECS  = 32'd4102444799;  // 2099-12-31 23:59:59
  localparam logic [31:0] DAY_SECS   = 32'd86400;
  localparam logic [15:0] CYCLE_DAYS = 16'd1461;        // four years, one leap
  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  // Exact reciprocals: ceil(2^S / d), error small enough for the dividend width
  localparam logic [25:0] RECIP_DAY  = 26'(((64'd1 << 35) + 64'd675 - 64'd1) / 64'd675);
  localparam logic [16:0] RECIP_CYC  = 17'(((64'd1 << 27) + 64'd1461 - 64'd1) / 64'd1461);
  localparam logic [17:0] RECIP_HOUR = 18'(((64'd1 << 29) + 64'd3600 - 64'd1) / 64'd3600);
  localparam logic [12:0] RECIP_MIN  = 13'(((64'd1 << 18) + 64'd60 - 64'd1) / 64'd60);

  // Data carried through the pipeline
  typedef struct packed {
    op_t         op;
    logic        err;
    // calendar to seconds
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
    logic [15:0] tdays;
    logic [16:0] tod;
    logic [31:0] secs;
    // seconds to calendar
    logic [31:0] tp;
    logic [15:0] days;
    logic [16:0] sod;
    logic [5:0]  cyc;
    logic [10:0] d4;
    logic [4:0]  hour;
    logic [11:0] rem;
    logic [6:0]  year;
    logic [8:0]  doy;
    logic        leap;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [5:0]  minute;
    logic [5:0]  second;
  } pipe_t;

  // Stage control handed from the control block to the datapath
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctrl_t;

  // Days in a month; zero for a month code that means nothing
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days of the year before the first of a month
  function automatic logic [8:0] cum_days(input logic [3:0] month, input logic leap);
    logic [8:0] n;
    case (month)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && month > 4'd2) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

// ===== sv/uctc_if.sv =====
`timescale 1ns / 1ps
// uctc_in_if / uctc_out_if: valid/ready channels for request and result words.
// No dependencies; the field widths are written out here.

interface uctc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] epoch_seconds;
  logic [11:0] year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic [4:0]  hour_in;
  logic [5:0]  minute_in;
  logic [5:0]  second_in;

  modport source (
    output valid, operation, epoch_seconds, year_in, month_in, day_in,
           hour_in, minute_in, second_in,
    input  ready
  );
  modport sink (
    input  valid, operation, epoch_seconds, year_in, month_in, day_in,
           hour_in, minute_in, second_in,
    output ready
  );
endinterface

interface uctc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds_out;
  logic [6:0]  year_offset;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic        range_error;

  modport source (
    output valid, epoch_seconds_out, year_offset, month_out, day_out,
           hour_out, minute_out, second_out, range_error,
    input  ready
  );
  modport sink (
    input  valid, epoch_seconds_out, year_offset, month_out, day_out,
           hour_out, minute_out, second_out, range_error,
    output ready
  );
endinterface

// ===== sv/uctc_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// uctc_pipe_ctrl: valid bits and per-stage load enables for the converter pipeline.
// Depends on uctc_pkg (NUM_STAGES, pipe_ctrl_t).
module uctc_pipe_ctrl
  import uctc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_ready,
  output pipe_ctrl_t ctrl
);

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] valid_next;
  logic [NUM_STAGES-1:0] adv;

  // A stage advances when it is empty or the stage after it advances,
  // so bubbles collapse while the output is stalled.
  always_comb begin
    adv[NUM_STAGES-1] = !valid[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
    valid_next[0] = adv[0] ? in_valid : valid[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_next[k] = adv[k] ? valid[k-1] : valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign ctrl.load  = adv;
  assign ctrl.valid = valid;

endmodule

// ===== sv/unix_time_calendar_converter.sv =====
`timescale 1ns / 1ps
// Unix seconds <-> calendar converter for the years 2000..2099, seven-stage pipeline.
// Depends on uctc_pkg, uctc_if (uctc_in_if, uctc_out_if) and uctc_pipe_ctrl.
//
// Usage:
//   request carries one word per conversion: operation selects calendar fields to
//   seconds (OP_TO_UNIX) or seconds to calendar fields (OP_FROM_UNIX). result
//   carries one word per request, in order. Years outside 2000..2099 (year_in
//   0..99 is taken as an offset from 2000 and accepted), timestamps or calendar
//   fields out of range give range_error = 1 with every other field zero; fields
//   that do not belong to the operation are zero. Each word passes stages 1 to 7
//   in order, and result is driven straight from the last stage register.
//   Throughput: one word per cycle while result is not stalled; each of the seven
//   stages holds one word and the divisions by 86400, 1461, 3600 and 60 are
//   reciprocal multiplies spread over separate stages.
//   Stall: when result.ready is low, words pile up behind the output register;
//   empty stages keep filling, and request.ready drops only once all seven
//   stages hold a word. Nothing is lost or repeated.
//   Reset: synchronous rst clears every valid bit; the pipeline comes up empty
//   and ready.
module unix_time_calendar_converter
  import uctc_pkg::*;
(
  input logic          clk,
  input logic          rst,
  uctc_in_if.sink      request,
  uctc_out_if.source   result
);

  pipe_ctrl_t ctrl;
  pipe_t      st  [NUM_STAGES];
  pipe_t      nxt [NUM_STAGES];

  logic [11:0] y12;
  logic [6:0]  y7;
  logic        leap_t;
  logic [4:0]  dim;
  logic        err_t;
  logic        err_f;
  logic [8:0]  base_t;
  logic [50:0] prod_day;
  logic [32:0] prod_cyc;
  logic [34:0] prod_hr;
  logic [24:0] prod_min;
  logic [31:0] sod_full;
  logic [15:0] d4_full;
  logic [15:0] rem_full;
  logic [15:0] sec_full;
  logic [3:0]  mon;
  logic [8:0]  base_f;
  logic [8:0]  day_full;
  logic        is_to;
  logic        is_from;

  uctc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .out_ready (result.ready),
    .ctrl      (ctrl)
  );

  assign request.ready = ctrl.load[0];

  always_comb begin
    for (int k = 1; k < NUM_STAGES; k++) begin
      nxt[k] = st[k-1];
    end

    // Stage 1: field checks, day count for calendar input, offset timestamp
    nxt[0]    = '0;
    nxt[0].op = op_t'(request.operation);
    nxt[0].hh = request.hour_in;
    nxt[0].mm = request.minute_in;
    nxt[0].ss = request.second_in;
    y12 = request.year_in;
    if (y12 >= 12'd2000) begin
      y12 = y12 - 12'd2000;
    end
    y7     = y12[6:0];
    leap_t = (y7[1:0] == 2'b00);
    dim    = month_days(request.month_in, leap_t);
    err_t  = (y12 > 12'd99) || (request.month_in == 4'd0) || (request.month_in > 4'd12) ||
             (request.day_in == 5'd0) || (request.day_in > dim) ||
             (request.hour_in > 5'd23) || (request.minute_in > 6'd59) ||
             (request.second_in > 6'd59);
    base_t = cum_days(request.month_in, leap_t);
    nxt[0].tdays = 16'(base_t) + 16'(request.day_in) - 16'd1 + 16'(y7) * 16'd365 +
                   16'((y7 + 7'd3) >> 2);
    err_f = (request.epoch_seconds < EPOCH_2000) || (request.epoch_seconds > LAST_SECS);
    nxt[0].err = (nxt[0].op == OP_FROM_UNIX) ? err_f : err_t;
    nxt[0].tp  = request.epoch_seconds - EPOCH_2000;

    // Stage 2: day number (tp / 86400 as (tp >> 7) / 675), day seconds, time of day
    prod_day     = {26'd0, st[0].tp[31:7]} * {25'd0, RECIP_DAY};
    nxt[1].days  = prod_day[50:35];
    nxt[1].secs  = 32'(st[0].tdays) * DAY_SECS;
    nxt[1].tod   = 17'(st[0].hh) * 17'd3600 + 17'(st[0].mm) * 17'd60 + 17'(st[0].ss);

    // Stage 3: seconds of day, four-year cycle, final seconds count
    sod_full     = st[1].tp - 32'(st[1].days) * DAY_SECS;
    nxt[2].sod   = sod_full[16:0];
    prod_cyc     = {16'd0, st[1].days} * {16'd0, RECIP_CYC};
    nxt[2].cyc   = prod_cyc[32:27];
    nxt[2].secs  = EPOCH_2000 + st[1].secs + 32'(st[1].tod);

    // Stage 4: hour, day within the cycle
    prod_hr      = {18'd0, st[2].sod} * {17'd0, RECIP_HOUR};
    nxt[3].hour  = prod_hr[33:29];
    d4_full      = st[2].days - 16'(st[2].cyc) * CYCLE_DAYS;
    nxt[3].d4    = d4_full[10:0];

    // Stage 5: seconds within the hour, year and day of year
    rem_full     = 16'(st[3].sod) - 16'(st[3].hour) * 16'd3600;
    nxt[4].rem   = rem_full[11:0];
    if (st[3].d4 < YEAR1_START) begin
      nxt[4].year = 7'({st[3].cyc, 2'b00});
      nxt[4].doy  = st[3].d4[8:0];
      nxt[4].leap = 1'b1;
    end else if (st[3].d4 < YEAR2_START) begin
      nxt[4].year = 7'({st[3].cyc, 2'b01});
      nxt[4].doy  = 9'(st[3].d4 - YEAR1_START);
      nxt[4].leap = 1'b0;
    end else if (st[3].d4 < YEAR3_START) begin
      nxt[4].year = 7'({st[3].cyc, 2'b10});
      nxt[4].doy  = 9'(st[3].d4 - YEAR2_START);
      nxt[4].leap = 1'b0;
    end else begin
      nxt[4].year = 7'({st[3].cyc, 2'b11});
      nxt[4].doy  = 9'(st[3].d4 - YEAR3_START);
      nxt[4].leap = 1'b0;
    end

    // Stage 6: minute, month and day of month
    prod_min      = {13'd0, st[4].rem} * {12'd0, RECIP_MIN};
    nxt[5].minute = prod_min[23:18];
    mon = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (st[4].doy >= cum_days(4'(i), st[4].leap)) begin
        mon = 4'(i);
      end
    end
    base_f        = cum_days(mon, st[4].leap);
    day_full      = st[4].doy - base_f + 9'd1;
    nxt[5].month  = mon;
    nxt[5].day    = day_full[4:0];

    // Stage 7: second, then zero what the operation or an error leaves unused
    sec_full = 16'(st[5].rem) - 16'(st[5].minute) * 16'd60;
    is_to    = (st[5].op == OP_TO_UNIX) && !st[5].err;
    is_from  = (st[5].op == OP_FROM_UNIX) && !st[5].err;
    nxt[6].secs   = is_to   ? st[5].secs   : 32'd0;
    nxt[6].year   = is_from ? st[5].year   : 7'd0;
    nxt[6].month  = is_from ? st[5].month  : 4'd0;
    nxt[6].day    = is_from ? st[5].day    : 5'd0;
    nxt[6].hour   = is_from ? st[5].hour   : 5'd0;
    nxt[6].minute = is_from ? st[5].minute : 6'd0;
    nxt[6].second = is_from ? sec_full[5:0] : 6'd0;
  end

  // Stage registers; payload only, valid bits live in the control block
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (ctrl.load[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  // Result channel straight from the last stage
  assign result.valid             = ctrl.valid[NUM_STAGES-1];
  assign result.epoch_seconds_out = st[NUM_STAGES-1].secs;
  assign result.year_offset       = st[NUM_STAGES-1].year;
  assign result.month_out         = st[NUM_STAGES-1].month;
  assign result.day_out           = st[NUM_STAGES-1].day;
  assign result.hour_out          = st[NUM_STAGES-1].hour;
  assign result.minute_out        = st[NUM_STAGES-1].minute;
  assign result.second_out        = st[NUM_STAGES-1].second;
  assign result.range_error       = st[NUM_STAGES-1].err;

  // A rejected word carries nothing but the flag
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.range_error |->
      result.epoch_seconds_out == 32'd0 && result.year_offset == 7'd0 &&
      result.month_out == 4'd0 && result.day_out == 5'd0 && result.hour_out == 5'd0 &&
      result.minute_out == 6'd0 && result.second_out == 6'd0)
    else $error("rejected word has nonzero fields");

  // Calendar fields and a seconds count never come out together
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.month_out != 4'd0 |-> result.epoch_seconds_out == 32'd0)
    else $error("calendar and seconds fields both set");

  // A decoded date is a real date
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.month_out != 4'd0 |->
      result.month_out <= 4'd12 && result.day_out != 5'd0 &&
      result.year_offset <= 7'd99 && result.hour_out <= 5'd23 &&
      result.minute_out <= 6'd59 && result.second_out <= 6'd59)
    else $error("decoded date out of range");

  // Input is held off only when every stage holds a word
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !request.ready |-> (&ctrl.valid) && !result.ready)
    else $error("input stalled with room in the pipeline");

endmodule
